// File: src/dnlp_pkg.sv
// ----------------------------------------------------------------------------
// dnlp_pkg
// Shared types, character codes and digit decode for the delimited number
// list parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dnlp_pkg;

	// Most tokens stored per string
	localparam int MAX_PARAMS = 16;
	// Stored-count width, able to hold MAX_PARAMS itself
	localparam int CNT_W = $clog2(MAX_PARAMS + 1);

	// Field widths fixed by the output port list
	localparam int VALUE_W = 32;
	localparam int IDX_W   = 4;
	localparam int PCNT_W  = 5;

	// Character codes
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_APOS  = 8'h27;
	localparam logic [7:0] CHAR_X_LO  = 8'h78;
	localparam logic [7:0] CHAR_X_UP  = 8'h58;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_A_UP  = 8'h41;
	localparam logic [7:0] CHAR_F_UP  = 8'h46;
	localparam logic [7:0] CHAR_A_LO  = 8'h61;
	localparam logic [7:0] CHAR_F_LO  = 8'h66;

	// Token and string state
	typedef struct packed {
		logic [VALUE_W-1:0] acc;
		logic [1:0]         pos;
		logic               hex;
		logic [CNT_W-1:0]   cnt;
		logic               err;
	} parse_state_t;

	// One result item
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [IDX_W-1:0]   idx;
		logic               has_value;
		logic               eos;
		logic               err;
		logic [PCNT_W-1:0]  cnt;
	} parse_result_t;

	// Decoded digit: ok is low for any character that is not a digit, A-F or a-f
	typedef struct packed {
		logic       ok;
		logic [3:0] d;
	} digit_t;

	function automatic digit_t digit_of(input logic [7:0] c);
		digit_t r;
		r.ok = 1'b1;
		r.d  = 4'd0;
		if (c >= CHAR_A_UP && c <= CHAR_F_UP) begin
			r.d = 4'(c - CHAR_A_UP + 8'd10);
		end else if (c >= CHAR_A_LO && c <= CHAR_F_LO) begin
			r.d = 4'(c - CHAR_A_LO + 8'd10);
		end else if (c >= CHAR_0 && c <= CHAR_9) begin
			r.d = 4'(c - CHAR_0);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/dnlp_step.sv
// ----------------------------------------------------------------------------
// dnlp_step
// Per-character step: classifies one character, updates token and string
// state and forms the result item, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module dnlp_step
	import dnlp_pkg::*;
(
	input  parse_state_t  state_cur,
	input  logic [7:0]    ch,
	output parse_state_t  state_nxt,
	output parse_result_t res,
	output logic          res_valid
);

	logic             counted;
	logic             is_sep;
	logic             is_x;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] cnt_fin;
	digit_t           dig;

	assign counted = state_cur.cnt < CNT_W'(MAX_PARAMS);
	assign is_sep  = (ch == CHAR_COMMA) || (ch == CHAR_COLON) || (ch == CHAR_APOS);
	assign is_x    = (ch == CHAR_X_LO) || (ch == CHAR_X_UP);
	assign cnt_inc = state_cur.cnt + CNT_W'(1);
	assign cnt_fin = counted ? cnt_inc : state_cur.cnt;
	assign dig     = digit_of(ch);

	// Next state and result
	always_comb begin
		state_nxt = state_cur;
		res       = '0;
		res_valid = 1'b0;
		priority if (ch == CHAR_NUL) begin
			// end of string: always one result, then back to reset state
			res_valid = 1'b1;
			res.eos   = 1'b1;
			res.err   = state_cur.err;
			if (counted && !state_cur.err) begin
				res.has_value = 1'b1;
				res.value     = state_cur.acc;
				res.idx       = IDX_W'(state_cur.cnt);
			end
			res.cnt   = state_cur.err ? '0 : PCNT_W'(cnt_fin);
			state_nxt = '0;
		end else if (is_sep) begin
			if (counted) begin
				if (!state_cur.err) begin
					res_valid     = 1'b1;
					res.has_value = 1'b1;
					res.value     = state_cur.acc;
					res.idx       = IDX_W'(state_cur.cnt);
				end
				state_nxt.cnt = cnt_inc;
			end
			state_nxt.acc = '0;
			state_nxt.pos = 2'd0;
			state_nxt.hex = 1'b0;
		end else begin
			if (counted) begin
				priority if (state_cur.pos == 2'd1 && !state_cur.hex &&
				             state_cur.acc == '0 && is_x) begin
					state_nxt.hex = 1'b1;
				end else if (!dig.ok) begin
					state_nxt.err = 1'b1;
				end else if (state_cur.hex) begin
					// times 16 plus digit
					state_nxt.acc = {state_cur.acc[VALUE_W-5:0], dig.d};
				end else begin
					// times 10 plus digit, as 8x + 2x
					state_nxt.acc = {state_cur.acc[VALUE_W-4:0], 3'b000} +
					                {state_cur.acc[VALUE_W-2:0], 1'b0} +
					                VALUE_W'(dig.d);
				end
			end
			if (state_cur.pos != 2'd2) begin
				state_nxt.pos = state_cur.pos + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/delimited_number_list_parser_top.sv
// ----------------------------------------------------------------------------
// delimited_number_list_parser_top
// Path: out_valid rises once an accepted char with a result has passed the input
// reg, then the result reg; stage 1 holds while the result reg is full and not taken.
// Throughput: one character per cycle while the result reg is free or being taken;
// each state update is a combinational classify plus multiply-add by 10 or 16.
// Characters that cause no result still take one slot in the pipeline.
// Reset: arst_n clears valid bits and all parse state; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_number_list_parser_top
	import dnlp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [7:0]  char_in,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [31:0] value,
	output      logic [3:0]  param_index,
	output      logic        has_value,
	output      logic        end_of_string,
	output      logic        parse_error,
	output      logic [4:0]  param_count
);

	logic          valid_s1;
	logic [7:0]    ch_s1;
	logic          valid_s2;
	parse_result_t res_s2;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res;
	logic          res_valid;
	logic          adv;

	// stage 1 moves on whenever the result register is free or being taken
	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1 <= char_in;
		end
	end

	dnlp_step u_step (
		.state_cur (state_q),
		.ch        (ch_s1),
		.state_nxt (state_nxt),
		.res       (res),
		.res_valid (res_valid)
	);

	// parse state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			if (valid_s1) begin
				state_q <= state_nxt;
			end
			valid_s2 <= valid_s1 && res_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign value         = res_s2.value;
	assign param_index   = res_s2.idx;
	assign has_value     = res_s2.has_value;
	assign end_of_string = res_s2.eos;
	assign parse_error   = res_s2.err;
	assign param_count   = res_s2.cnt;

`ifndef SYNTHESIS
	// an accepted character always lands in stage 1
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item did not reach stage 1");

	// a separator result carries a value and no end-of-string fields
	a_sep_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_string |-> has_value && !parse_error && param_count == '0)
		else $error("separator result with final-result fields set");

	// an error result reports no count and no value
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_error |-> end_of_string && !has_value && param_count == '0)
		else $error("error result carries a value or count");

	// stored count never passes the limit
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cnt <= CNT_W'(MAX_PARAMS))
		else $error("stored count beyond limit");

	// after end of string the parse state is back at reset
	a_eos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && ch_s1 == CHAR_NUL |=> state_q == '0)
		else $error("state not cleared after end of string");
`endif

endmodule

`default_nettype wire
